@@ rtl/sha1bsh_pkg.sv @@
package sha1bsh_pkg;

    localparam int NUM_WORDS   = 5;
    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int LEN_START   = 56;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int WIDX_W      = $clog2(NUM_WORDS);

    typedef logic [31:0] word_t;
    typedef logic [NUM_WORDS-1:0][31:0] hash_t;

    localparam hash_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // message schedule controls
    typedef struct packed {
        logic       push;
        logic [7:0] pbyte;
        logic       step;
        logic       expand;
    } sched_ctrl_t;

    // compression round controls
    typedef struct packed {
        logic               load;
        logic               step;
        logic [ROUND_W-1:0] round_idx;
    } round_ctrl_t;

endpackage

@@ rtl/sha1_byte_stream_hasher.sv @@
// channel | signals                                 | item
// --------+-----------------------------------------+-----------------------------------
// in      | in_valid in_ready data_byte byte_valid   | one message byte and/or end mark
//         | end_of_message                          |
// out     | out_valid out_ready digest_word          | one digest word, five per message
//         | word_index last_word                    |
//
// A byte item is shifted into the block buffer; one that completes a 64-byte block
// then runs 80 rounds of the shared round unit and one chaining add.
// An end item pushes pad and length bytes one a cycle through the block
// buffer, compresses one or two blocks, then offers five words, which are
// held while out_ready is low. in_ready is low while busy.
// Asynchronous reset loads the initial hash words and clears length and fill.
module sha1_byte_stream_hasher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               byte_valid,
    input  logic               end_of_message,
    output logic               out_valid,
    input  logic               out_ready,
    output sha1bsh_pkg::word_t digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);
    import sha1bsh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [63:0]        bitlen_reg, bitlen_next;
    hash_t              chain_reg, chain_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;
    logic               eom_reg, eom_next;
    logic               pad_reg, pad_next;
    logic               first_reg, first_next;
    logic               lenok_reg, lenok_next;

    sched_ctrl_t sctl;
    round_ctrl_t rctl;
    word_t       wt;
    hash_t       work;

    sha1bsh_sched u_sched (
        .clk  (clk),
        .ctrl (sctl),
        .wt   (wt)
    );

    sha1bsh_round u_round (
        .clk  (clk),
        .ctrl (rctl),
        .init (chain_reg),
        .wt   (wt),
        .work (work)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bitlen_next = bitlen_reg;
        chain_next  = chain_reg;
        round_next  = round_reg;
        widx_next   = widx_reg;
        eom_next    = eom_reg;
        pad_next    = pad_reg;
        first_next  = first_reg;
        lenok_next  = lenok_reg;

        in_ready    = 1'b0;
        out_valid   = 1'b0;
        sctl.push   = 1'b0;
        sctl.pbyte  = data_byte;
        sctl.step   = 1'b0;
        sctl.expand = (round_reg >= ROUND_W'(BLOCK_WORDS));
        rctl.load   = 1'b0;
        rctl.step   = 1'b0;
        rctl.round_idx = round_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    eom_next = end_of_message;
                    if (byte_valid)
                    begin
                        sctl.push   = 1'b1;
                        bitlen_next = bitlen_reg + 64'd8;
                        fill_next   = fill_reg + 1'b1;
                        if (fill_reg == FILL_W'(BLOCK_BYTES - 1))
                        begin
                            rctl.load  = 1'b1;
                            state_next = S_COMP;
                        end
                        else if (end_of_message)
                        begin
                            pad_next   = 1'b1;
                            first_next = 1'b1;
                            state_next = S_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                sctl.push = 1'b1;
                fill_next = fill_reg + 1'b1;
                if (first_reg)
                begin
                    sctl.pbyte = PAD_BYTE;
                    first_next = 1'b0;
                    // length fits in this block only if the mark lands before it
                    lenok_next = (fill_reg < FILL_W'(LEN_START));
                end
                else if (lenok_reg && fill_reg >= FILL_W'(LEN_START))
                begin
                    sctl.pbyte  = bitlen_reg[63:56];
                    bitlen_next = {bitlen_reg[55:0], 8'h00};
                end
                else
                begin
                    sctl.pbyte = 8'h00;
                end
                if (fill_reg == FILL_W'(BLOCK_BYTES - 1))
                begin
                    rctl.load  = 1'b1;
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                rctl.step = 1'b1;
                sctl.step = 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (pad_reg && lenok_reg)
                begin
                    widx_next  = '0;
                    state_next = S_OUT;
                end
                else if (pad_reg)
                begin
                    // overflow block done, length goes in the next one
                    lenok_next = 1'b1;
                    state_next = S_PAD;
                end
                else if (eom_reg)
                begin
                    pad_next   = 1'b1;
                    first_next = 1'b1;
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (widx_reg == WIDX_W'(NUM_WORDS - 1))
                    begin
                        chain_next  = H_INIT;
                        bitlen_next = '0;
                        fill_next   = '0;
                        pad_next    = 1'b0;
                        eom_next    = 1'b0;
                        lenok_next  = 1'b0;
                        widx_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        widx_next = widx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            bitlen_reg <= '0;
            chain_reg  <= H_INIT;
            round_reg  <= '0;
            widx_reg   <= '0;
            eom_reg    <= 1'b0;
            pad_reg    <= 1'b0;
            first_reg  <= 1'b0;
            lenok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            chain_reg  <= chain_next;
            round_reg  <= round_next;
            widx_reg   <= widx_next;
            eom_reg    <= eom_next;
            pad_reg    <= pad_next;
            first_reg  <= first_next;
            lenok_reg  <= lenok_next;
        end
    end

    assign digest_word = chain_reg[widx_reg];
    assign word_index  = 3'(widx_reg);
    assign last_word   = (widx_reg == WIDX_W'(NUM_WORDS - 1));

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest pending");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && round_reg == ROUND_W'(ROUNDS - 1)) |=> state_reg == S_ADD)
        else $error("compression did not finish after last round");

    a_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> fill_reg == '0)
        else $error("block buffer not empty after compression");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=>
            (bitlen_reg == '0 && fill_reg == '0 && chain_reg == H_INIT))
        else $error("state not reinitialized after digest");

    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> widx_reg <= WIDX_W'(NUM_WORDS - 1))
        else $error("word index out of range");

endmodule

@@ rtl/sha1bsh_sched.sv @@
module sha1bsh_sched (
    input  logic                     clk,
    input  sha1bsh_pkg::sched_ctrl_t ctrl,
    output sha1bsh_pkg::word_t       wt
);
    import sha1bsh_pkg::*;

    word_t buf_reg  [BLOCK_WORDS];
    word_t buf_next [BLOCK_WORDS];
    word_t mix;

    // buf_reg[0] is W[t-16], buf_reg[2] W[t-14], buf_reg[8] W[t-8], buf_reg[13] W[t-3]
    always_comb
    begin
        mix = buf_reg[13] ^ buf_reg[8] ^ buf_reg[2] ^ buf_reg[0];
        wt  = ctrl.expand ? {mix[30:0], mix[31]} : buf_reg[0];
    end

    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (ctrl.push)
        begin
            // whole block moves up one byte, new byte at the bottom
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                buf_next[i] = {buf_reg[i][23:0], buf_reg[i+1][31:24]};
            end
            buf_next[BLOCK_WORDS-1] = {buf_reg[BLOCK_WORDS-1][23:0], ctrl.pbyte};
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[BLOCK_WORDS-1] = wt;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

endmodule

@@ rtl/sha1bsh_round.sv @@
module sha1bsh_round (
    input  logic                     clk,
    input  sha1bsh_pkg::round_ctrl_t ctrl,
    input  sha1bsh_pkg::hash_t       init,
    input  sha1bsh_pkg::word_t       wt,
    output sha1bsh_pkg::hash_t       work
);
    import sha1bsh_pkg::*;

    hash_t work_reg;
    hash_t work_next;
    word_t a, b, c, d, e;
    word_t f, k, t;

    always_comb
    begin
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        d = work_reg[3];
        e = work_reg[4];
        if (ctrl.round_idx inside {[0:19]})
        begin
            f = (b & c) | (~b & d);
            k = K_0;
        end
        else if (ctrl.round_idx inside {[20:39]})
        begin
            f = b ^ c ^ d;
            k = K_1;
        end
        else if (ctrl.round_idx inside {[40:59]})
        begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = K_3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + wt;

        work_next = work_reg;
        if (ctrl.load)
        begin
            work_next = init;
        end
        else if (ctrl.step)
        begin
            work_next[0] = t;
            work_next[1] = a;
            work_next[2] = {b[1:0], b[31:2]};
            work_next[3] = c;
            work_next[4] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule
